/* rtl/core/tra_pkg.sv */
// Shared widths, control structs and the arcsine lookup table of the roll-angle core.
`timescale 1ns / 1ps

package tra_pkg;

  // Group size and table depth
  localparam int SAMPLES_PER_READING = 16;
  localparam int ASIN_TABLE_DEPTH    = 256;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int CFG_W    = 10;
  localparam int ROLL_W   = 15;
  localparam int SUM_W    = 18;
  localparam int CNT_W    = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

  // Ratio: 16-bit magnitude in units of 2^-15, 15 quotient bits from the divider
  localparam int FRAC_W = 15;
  localparam int MAG_W  = FRAC_W + 1;
  localparam int STEP_W = $clog2(FRAC_W + 1);

  // Table: angles in 1/256 centidegree, 90 degrees at the top entry
  localparam int TAB_W  = 22;
  localparam int IDX_W  = $clog2(ASIN_TABLE_DEPTH + 1);
  localparam int P_W    = MAG_W + $clog2(ASIN_TABLE_DEPTH);
  localparam int CD_W   = TAB_W - 8;

  localparam longint NINETY_UNITS = 64'd2304000;
  localparam longint PI_Q30       = 64'd3373259426;

  // Register indexes of the configuration port
  localparam int CFG_ADDR_W       = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_G = 1'd1;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] ZERO_OFFSET_RST  = 10'd512;
  localparam logic [CFG_W-1:0] COUNTS_PER_G_RST = 10'd205;

  // Completed group from the accumulator
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] total;
  } grp_t;

  // Signed, clamped ratio from the divider
  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             clip;
    logic [MAG_W-1:0] mag;
  } div_res_t;

  // Finished angle from the interpolator
  typedef struct packed {
    logic                     vld;
    logic signed [ROLL_W-1:0] roll;
    logic                     clip;
  } roll_res_t;

  typedef logic [TAB_W-1:0] asin_tab_t [0:ASIN_TABLE_DEPTH];

  // Q30 sine of angle t (1/256 centidegree), Taylor series through x^15
  function automatic longint sine_q30(longint t);
    longint unsigned r;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    r    = (longint'(t) * PI_Q30) / 4608000;
    x2   = (r * r) >> 30;
    term = r;
    acc  = longint'(term);
    term = ((term * x2) >> 30) / 6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 110;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 156;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 210;
    acc  = acc - longint'(term);
    return acc;
  endfunction

  // Build the arcsine table by bisection on the sine, kept monotone
  function automatic asin_tab_t build_tab();
    asin_tab_t tab;
    longint    lo;
    longint    hi;
    longint    mid;
    longint    target;
    longint    prev;
    tab[0] = '0;
    prev   = 0;
    for (int i = 1; i < ASIN_TABLE_DEPTH; i++) begin
      target = (longint'(i) << 30) / ASIN_TABLE_DEPTH;
      lo = 0;
      hi = NINETY_UNITS;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (sine_q30(mid) <= target) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      if (lo < prev) begin
        lo = prev;
      end
      tab[i] = TAB_W'(lo);
      prev   = lo;
    end
    tab[ASIN_TABLE_DEPTH] = TAB_W'(NINETY_UNITS);
    return tab;
  endfunction

  localparam asin_tab_t ASIN_TAB = build_tab();

endpackage

/* rtl/core/tilt_roll_angle_from_accel_core.sv */
// Top level of the roll-angle core: registers, channel handshakes and output register.
// Path from closing word to result: prepare, divide (skipped at or beyond one g),
//   table reads, multiply, hand-off and output register. A group closing right
//   behind another can wait on the interpolator. One sample word per cycle, except
//   that a closing word stalls while the divider still holds the previous group.
// Reset (rst_n low, synchronous) clears sum, sequencers and output; loads 512 and 205.
`timescale 1ns / 1ps

module tilt_roll_angle_from_accel_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // Sample channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [9:0] sample
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [14:0] roll_centideg, [15] clipped
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [tra_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tra_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [tra_pkg::CFG_W-1:0]        zero_offset_r;
  logic [tra_pkg::CFG_W-1:0]        counts_per_g_r;
  logic                             out_vld_r;
  logic signed [tra_pkg::ROLL_W-1:0] out_roll_r;
  logic                             out_clip_r;

  logic                             smp_acc;
  logic                             last;
  logic                             div_idle;
  logic                             div_take;
  logic                             res_ack;
  tra_pkg::grp_t                    grp;
  tra_pkg::div_res_t                div_res;
  tra_pkg::roll_res_t               roll_res;

  // Stall only the closing word while the divider still holds a group
  assign in_tready = !last || div_idle;
  assign smp_acc   = in_tvalid && in_tready;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r  <= tra_pkg::ZERO_OFFSET_RST;
      counts_per_g_r <= tra_pkg::COUNTS_PER_G_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tra_pkg::REG_ZERO_OFFSET:  zero_offset_r  <= cfg_wdata;
        tra_pkg::REG_COUNTS_PER_G: counts_per_g_r <= cfg_wdata;
        default:                   zero_offset_r  <= zero_offset_r;
      endcase
    end
  end

  tra_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .smp_acc (smp_acc),
    .smp     (in_tdata[tra_pkg::SAMPLE_W-1:0]),
    .last    (last),
    .grp     (grp)
  );

  tra_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .grp          (grp),
    .zero_offset  (zero_offset_r),
    .counts_per_g (counts_per_g_r),
    .take         (div_take),
    .idle         (div_idle),
    .res          (div_res)
  );

  tra_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_res (div_res),
    .take    (div_take),
    .res_ack (res_ack),
    .res     (roll_res)
  );

  // Load the output register when it is empty or being drained
  assign res_ack = roll_res.vld && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ack) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_roll_r <= roll_res.roll;
      out_clip_r <= roll_res.clip;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_clip_r, out_roll_r};

endmodule

/* rtl/core/tra_accum.sv */
// Sample accumulator: sums a group of conversions and flags the one that completes it.
`timescale 1ns / 1ps

module tra_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         smp_acc,
  input  logic [tra_pkg::SAMPLE_W-1:0] smp,
  output logic                         last,
  output tra_pkg::grp_t                grp
);

  logic [tra_pkg::SUM_W-1:0] sum_r;
  logic [tra_pkg::SUM_W-1:0] sum_nxt;
  logic [tra_pkg::CNT_W-1:0] cnt_r;

  // Flag the word that closes the group
  assign last    = (cnt_r == tra_pkg::CNT_W'(tra_pkg::SAMPLES_PER_READING - 1));
  assign sum_nxt = sum_r + tra_pkg::SUM_W'(smp);

  assign grp.done  = smp_acc && last;
  assign grp.total = sum_nxt;

  // Advance the running sum, clear it when the group closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (smp_acc) begin
      if (last) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/tra_div.sv */
// Ratio unit: average, offset difference, clamp and bit-serial restoring divide.
`timescale 1ns / 1ps

module tra_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tra_pkg::grp_t             grp,
  input  logic [tra_pkg::CFG_W-1:0] zero_offset,
  input  logic [tra_pkg::CFG_W-1:0] counts_per_g,
  input  logic                      take,
  output logic                      idle,
  output tra_pkg::div_res_t         res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]                      state_r;
  logic [tra_pkg::SUM_W-1:0]       total_r;
  logic [tra_pkg::CFG_W-1:0]       rem_r;
  logic [tra_pkg::FRAC_W-1:0]      quo_r;
  logic [tra_pkg::STEP_W-1:0]      step_r;
  logic                            neg_r;
  logic                            clip_r;
  logic                            full_r;

  logic [tra_pkg::SUM_W-1:0]       avg_w;
  logic [tra_pkg::SAMPLE_W-1:0]    avg;
  logic signed [tra_pkg::CFG_W:0]  diff;
  logic [tra_pkg::CFG_W-1:0]       amag;
  logic [tra_pkg::CFG_W-1:0]       cpg;
  logic [tra_pkg::CFG_W:0]         rem2;
  logic                            ge;
  logic [tra_pkg::CFG_W:0]         rem_sub;

  // Average, signed difference and divisor with zero taken as one
  assign avg_w = tra_pkg::SUM_W'(total_r / tra_pkg::SAMPLES_PER_READING);
  assign avg   = avg_w[tra_pkg::SAMPLE_W-1:0];
  assign diff  = $signed({1'b0, zero_offset}) - $signed({1'b0, avg});
  assign amag  = diff[tra_pkg::CFG_W] ? tra_pkg::CFG_W'(-diff) : diff[tra_pkg::CFG_W-1:0];
  assign cpg   = (counts_per_g == '0) ? tra_pkg::CFG_W'(1) : counts_per_g;

  // One quotient bit per cycle
  assign rem2    = {rem_r, 1'b0};
  assign ge      = (rem2 >= {1'b0, cpg});
  assign rem_sub = ge ? (rem2 - {1'b0, cpg}) : rem2;

  assign idle     = (state_r == S_IDLE);
  assign res.vld  = (state_r == S_HOLD);
  assign res.neg  = neg_r;
  assign res.clip = clip_r;
  assign res.mag  = full_r ? {1'b1, {tra_pkg::FRAC_W{1'b0}}} : {1'b0, quo_r};

  // Sequence: capture, prepare, divide (skipped when the magnitude reaches the divisor), hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (grp.done) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          state_r <= (amag >= cpg) ? S_HOLD : S_RUN;
        end
        S_RUN: begin
          if (step_r == tra_pkg::STEP_W'(1)) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (grp.done) begin
          total_r <= grp.total;
        end
      end
      S_PREP: begin
        neg_r  <= diff[tra_pkg::CFG_W];
        clip_r <= (amag > cpg);
        full_r <= (amag >= cpg);
        rem_r  <= amag;
        quo_r  <= '0;
        step_r <= tra_pkg::STEP_W'(tra_pkg::FRAC_W);
      end
      S_RUN: begin
        rem_r  <= rem_sub[tra_pkg::CFG_W-1:0];
        quo_r  <= {quo_r[tra_pkg::FRAC_W-2:0], ge};
        step_r <= step_r - 1'b1;
      end
      S_HOLD: begin
        total_r <= total_r;
      end
      default: total_r <= total_r;
    endcase
  end

endmodule

/* rtl/core/tra_interp.sv */
// Arcsine unit: table reads, bit-serial interpolation multiply and sign.
`timescale 1ns / 1ps

module tra_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  tra_pkg::div_res_t div_res,
  output logic              take,
  input  logic              res_ack,
  output tra_pkg::roll_res_t res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]                   state_r;
  logic [tra_pkg::IDX_W-1:0]    idx_r;
  logic [tra_pkg::FRAC_W-1:0]   frac_r;
  logic                         neg_r;
  logic                         clip_r;
  logic [tra_pkg::TAB_W-1:0]    rom_q_r;
  logic [tra_pkg::TAB_W-1:0]    t0_r;
  logic [tra_pkg::TAB_W-1:0]    d_r;
  logic [tra_pkg::TAB_W:0]      acc_r;
  logic [tra_pkg::STEP_W-1:0]   step_r;

  logic [tra_pkg::P_W-1:0]      p;
  logic [tra_pkg::IDX_W-1:0]    idx_up;
  logic [tra_pkg::IDX_W-1:0]    rd_addr;
  logic [tra_pkg::TAB_W:0]      acc_sum;
  logic [tra_pkg::TAB_W-1:0]    v;
  logic [tra_pkg::CD_W-1:0]     cd;
  logic signed [tra_pkg::ROLL_W-1:0] cd_s;

  assign take = div_res.vld && (state_r == S_IDLE);

  // Table position and fraction of the ratio
  assign p = tra_pkg::P_W'(div_res.mag) * tra_pkg::P_W'(tra_pkg::ASIN_TABLE_DEPTH);

  // Upper neighbor, held at the top entry
  assign idx_up  = (idx_r == tra_pkg::IDX_W'(tra_pkg::ASIN_TABLE_DEPTH)) ? idx_r
                 : idx_r + 1'b1;
  assign rd_addr = (state_r == S_RD1) ? idx_up : idx_r;

  // Read the table one entry per cycle
  always_ff @(posedge clk) begin
    rom_q_r <= tra_pkg::ASIN_TAB[rd_addr];
  end

  // LSB-first shift-add keeps the floor of d * frac / 2^15 exact
  assign acc_sum = acc_r + (frac_r[0] ? {1'b0, d_r} : '0);

  // Final angle and sign
  assign v    = t0_r + acc_r[tra_pkg::TAB_W-1:0];
  assign cd   = v[tra_pkg::TAB_W-1:8];
  assign cd_s = $signed(tra_pkg::ROLL_W'(cd));

  assign res.vld  = (state_r == S_HOLD);
  assign res.roll = neg_r ? -cd_s : cd_s;
  assign res.clip = clip_r;

  // Sequence the reads, the multiply and the hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (take) state_r <= S_RD0;
        S_RD0:  state_r <= S_RD1;
        S_RD1:  state_r <= S_LD;
        S_LD:   state_r <= S_MUL;
        S_MUL: begin
          if (step_r == tra_pkg::STEP_W'(1)) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: if (res_ack) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          idx_r  <= p[tra_pkg::FRAC_W +: tra_pkg::IDX_W];
          frac_r <= p[tra_pkg::FRAC_W-1:0];
          neg_r  <= div_res.neg;
          clip_r <= div_res.clip;
        end
      end
      S_RD0: begin
        acc_r <= '0;
      end
      S_RD1: begin
        t0_r <= rom_q_r;
      end
      S_LD: begin
        d_r    <= rom_q_r - t0_r;
        acc_r  <= '0;
        step_r <= tra_pkg::STEP_W'(tra_pkg::FRAC_W);
      end
      S_MUL: begin
        acc_r  <= acc_sum >> 1;
        frac_r <= frac_r >> 1;
        step_r <= step_r - 1'b1;
      end
      S_HOLD: begin
        acc_r <= acc_r;
      end
      default: acc_r <= acc_r;
    endcase
  end

endmodule
